### rtl/sme_pkg.sv
// Shared constants, command codes and error codes for the stack machine executor.
package sme_pkg;
  localparam int StackDepth = 256;
  localparam int SpW        = $clog2(StackDepth);
  localparam int CntW       = SpW + 1;
  localparam int AddrW      = 16;
  localparam int DataW      = 32;

  typedef enum logic [3:0] {
    CMD_PUSH  = 4'd0,  CMD_ADD  = 4'd1,  CMD_SUB   = 4'd2,  CMD_MUL  = 4'd3,
    CMD_DIV   = 4'd4,  CMD_DUMP = 4'd5,  CMD_EQ    = 4'd6,  CMD_IF   = 4'd7,
    CMD_ELSE  = 4'd8,  CMD_END  = 4'd9,  CMD_DUP   = 4'd10, CMD_GT   = 4'd11,
    CMD_LT    = 4'd12, CMD_WHILE = 4'd13, CMD_DO   = 4'd14, CMD_ILL  = 4'd15
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2,
    ERR_DIVZ = 3'd3, ERR_ILL   = 3'd4, ERR_HALT = 3'd5
  } err_t;

  // Divider handshake between sequencer and divide unit.
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;
endpackage

### rtl/sme_stack_ram.sv
// Data stack storage: one write port, one registered read port.
module sme_stack_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [sme_pkg::SpW-1:0]     waddr,
  input  logic [sme_pkg::DataW-1:0]   wdata,
  input  logic [sme_pkg::SpW-1:0]     raddr,
  output logic [sme_pkg::DataW-1:0]   rdata
);
  import sme_pkg::*;

  logic [DataW-1:0] mem [StackDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/sme_divider.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module sme_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  sme_pkg::div_req_t req,
  output sme_pkg::div_rsp_t rsp
);
  import sme_pkg::*;

  localparam int CntBits = $clog2(DataW + 1);

  logic             busy_r, busy_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic [DataW-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic             neg_r, neg_nxt, done_r, done_nxt;
  logic [DataW:0]   trial;
  logic [DataW-1:0] shifted;

  always_comb begin
    busy_nxt = busy_r; cnt_nxt = cnt_r; rem_nxt = rem_r; quo_nxt = quo_r;
    dvs_nxt = dvs_r; neg_nxt = neg_r; done_nxt = 1'b0;
    shifted = {rem_r[DataW-2:0], quo_r[DataW-1]};
    trial = {1'b0, shifted} - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntBits'(DataW);
      rem_nxt  = '0;
      quo_nxt  = req.dividend[DataW-1] ? -req.dividend : req.dividend;
      dvs_nxt  = req.divisor[DataW-1] ? -req.divisor : req.divisor;
      neg_nxt  = req.dividend[DataW-1] ^ req.divisor[DataW-1];
    end else if (busy_r) begin
      // rem/quo shift left together; quotient bits fill from the right
      if (!trial[DataW]) begin
        rem_nxt = trial[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[DataW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntBits'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -quo_r : quo_r;

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("divider done without busy");

  property p_no_start_busy;
    @(posedge clk) disable iff (!rst_n) busy_r |-> !req.start;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy)
    else $error("divider restarted while busy");

  property p_busy_cnt;
    @(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0;
  endproperty
  a_busy_cnt: assert property (p_busy_cnt)
    else $error("divider count ran out while busy");
endmodule

### rtl/stack_machine_executor_unit.sv
// Top level of the stack machine executor: sequencer around the stack memory.
// Executes one stack-language instruction per accepted input word against a
// 256-entry stack of signed 32-bit values held in a synchronous RAM, and
// returns one result word per instruction (next address, dump value, error,
// done flag). Items run one at a time. The top two stack entries are read
// through the single RAM read port one after the other, so an instruction
// needing two operands passes through S_RDA and S_RDB before S_EXEC, a
// one-operand instruction through S_RDA alone, and one with none goes
// straight to S_EXEC. Multiply waits in S_DIV for the registered product;
// divide waits there for the bit-serial divider. Faults go through S_DONE.
// A result can sit in the output register while the next input word is
// accepted and executed; the new result waits in the sequencer until the
// old one is taken. Any fault halts the block until reset; afterwards every
// word returns error 5.
module stack_machine_executor_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    in_command,
  input  logic signed [31:0]            in_operand,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_next_address,
  output logic                          out_dump_valid,
  output logic signed [31:0]            out_dump_value,
  output logic [2:0]                    out_error_code,
  output logic                          out_program_done
);
  import sme_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RDA, S_RDB, S_EXEC, S_DIV, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [AddrW-1:0]   pc_r, pc_nxt;
  logic               halt_r, halt_nxt;
  logic [15:0]        plen_r;
  cmd_t               cmd_r, cmd_nxt;
  logic [DataW-1:0]   opnd_r, opnd_nxt;
  logic [DataW-1:0]   a_r, a_nxt;
  logic               ov_r, ov_nxt;
  logic [AddrW-1:0]   o_addr_r, o_addr_nxt;
  logic               o_dv_r, o_dv_nxt;
  logic [DataW-1:0]   o_val_r, o_val_nxt;
  err_t               o_err_r, o_err_nxt;
  // output register, loaded from the o_* result once it is complete
  logic [AddrW-1:0]   q_addr_r;
  logic               q_dv_r;
  logic [DataW-1:0]   q_val_r;
  err_t               q_err_r;
  logic               oload;

  logic               we;
  logic [SpW-1:0]     waddr, raddr;
  logic [DataW-1:0]   wdata, rdata;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic [1:0]         need;
  logic               accept;
  logic [AddrW-1:0]   target;
  logic [DataW-1:0]   res;
  logic               fin;
  logic [AddrW-1:0]   fin_pc;
  logic [DataW-1:0]   prod_r;

  sme_stack_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  sme_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Next word is taken whenever the sequencer is idle; a finished result
  // waits in S_EXEC/S_DONE until the output register is free.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    unique case (cmd_t'(in_command)) inside
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQ, CMD_GT, CMD_LT: need = 2'd2;
      CMD_DUMP, CMD_IF, CMD_DUP, CMD_DO:                          need = 2'd1;
      default:                                                   need = 2'd0;
    endcase
  end

  assign target = opnd_r[AddrW-1:0];

  always_comb begin
    case (cmd_r)
      CMD_ADD: res = a_r + rdata;
      CMD_SUB: res = a_r - rdata;
      CMD_EQ:  res = {31'd0, a_r == rdata};
      CMD_GT:  res = {31'd0, $signed(a_r) > $signed(rdata)};
      CMD_LT:  res = {31'd0, $signed(a_r) < $signed(rdata)};
      default: res = a_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= a_r * rdata;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; pc_nxt = pc_r; halt_nxt = halt_r;
    cmd_nxt = cmd_r; opnd_nxt = opnd_r; a_nxt = a_r; ov_nxt = ov_r;
    o_addr_nxt = o_addr_r; o_dv_nxt = o_dv_r; o_val_nxt = o_val_r; o_err_nxt = o_err_r;
    we = 1'b0; waddr = cnt_r[SpW-1:0]; wdata = opnd_r;
    raddr = SpW'(cnt_r - 1'b1);
    dreq.start = 1'b0; dreq.dividend = a_r; dreq.divisor = rdata;
    fin = 1'b0; fin_pc = pc_r; oload = 1'b0;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = cmd_t'(in_command);
          opnd_nxt = in_operand;
          o_addr_nxt = pc_r; o_dv_nxt = 1'b0; o_val_nxt = '0;
          if (halt_r) begin
            o_err_nxt = ERR_HALT; state_nxt = S_DONE;
          end else if (cmd_t'(in_command) == CMD_ILL) begin
            o_err_nxt = ERR_ILL; halt_nxt = 1'b1; state_nxt = S_DONE;
          end else if (cnt_r < CntW'(need)) begin
            o_err_nxt = ERR_UNDER; halt_nxt = 1'b1; state_nxt = S_DONE;
          end else if ((cmd_t'(in_command) == CMD_PUSH || cmd_t'(in_command) == CMD_DUP)
                       && cnt_r == CntW'(StackDepth)) begin
            o_err_nxt = ERR_OVER; halt_nxt = 1'b1; state_nxt = S_DONE;
          end else if (need == 2'd0) begin
            o_err_nxt = ERR_NONE;
            if (cmd_t'(in_command) == CMD_PUSH) begin
              we = 1'b1; wdata = in_operand;
              cnt_nxt = cnt_r + 1'b1;
            end
            state_nxt = S_EXEC;
          end else begin
            o_err_nxt = ERR_NONE;
            state_nxt = S_RDA; // top entry read issued now
          end
        end
      end
      S_RDA: begin
        a_nxt = rdata;
        raddr = SpW'(cnt_r - 2'd2);
        if (cmd_r == CMD_ADD || cmd_r == CMD_SUB || cmd_r == CMD_MUL || cmd_r == CMD_DIV ||
            cmd_r == CMD_EQ || cmd_r == CMD_GT || cmd_r == CMD_LT) begin
          state_nxt = S_RDB;
        end else begin
          state_nxt = S_EXEC;
          unique case (cmd_r) inside
            CMD_DUMP: begin
              cnt_nxt = cnt_r - 1'b1; o_dv_nxt = 1'b1; o_val_nxt = rdata;
            end
            CMD_IF, CMD_DO: begin
              cnt_nxt = cnt_r - 1'b1;
              if (rdata == '0) fin_pc = target;
            end
            CMD_DUP: begin
              we = 1'b1; wdata = rdata; cnt_nxt = cnt_r + 1'b1;
            end
            default: ;
          endcase
          fin = 1'b1;
        end
      end
      S_RDB: begin
        if (cmd_r == CMD_DIV) begin
          if (rdata == '0) begin
            o_err_nxt = ERR_DIVZ; halt_nxt = 1'b1; state_nxt = S_DONE;
          end else begin
            dreq.start = 1'b1; state_nxt = S_DIV;
          end
        end else if (cmd_r == CMD_MUL) begin
          state_nxt = S_DIV; // the product is registered; it is written back in S_DIV
        end else begin
          we = 1'b1; waddr = SpW'(cnt_r - 2'd2); wdata = res;
          cnt_nxt = cnt_r - 1'b1; fin = 1'b1; state_nxt = S_EXEC;
        end
      end
      S_DIV: begin
        if (cmd_r == CMD_MUL || drsp.done) begin
          we = 1'b1; waddr = SpW'(cnt_r - 2'd2);
          wdata = (cmd_r == CMD_MUL) ? prod_r : drsp.quotient;
          cnt_nxt = cnt_r - 1'b1; fin = 1'b1; state_nxt = S_EXEC;
        end
      end
      S_EXEC, S_DONE: begin
        // hand over once the output register is empty or draining
        if (!ov_r || !out_stall) begin
          oload = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Branches that need no stack read resolve here too.
    if (state_r == S_IDLE && state_nxt == S_EXEC) begin
      fin = 1'b1;
      if (cmd_t'(in_command) == CMD_ELSE) fin_pc = in_operand[AddrW-1:0];
      else if (cmd_t'(in_command) == CMD_END && in_operand[AddrW-1:0] != '0)
        fin_pc = in_operand[AddrW-1:0];
    end
    if (fin) begin
      pc_nxt = (fin_pc == pc_r) ? pc_r + 1'b1 : fin_pc;
      o_addr_nxt = pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pc_r    <= '0;
      halt_r  <= 1'b0;
      plen_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) plen_r <= cfg_wdata;
    end
    cmd_r <= cmd_nxt; opnd_r <= opnd_nxt; a_r <= a_nxt;
    o_addr_r <= o_addr_nxt; o_dv_r <= o_dv_nxt; o_val_r <= o_val_nxt; o_err_r <= o_err_nxt;
    if (oload) begin
      q_addr_r <= o_addr_r; q_dv_r <= o_dv_r; q_val_r <= o_val_r; q_err_r <= o_err_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_next_address = q_addr_r;
  assign out_dump_valid   = q_dv_r;
  assign out_dump_value   = q_val_r;
  assign out_error_code   = q_err_r;
  assign out_program_done = q_addr_r >= plen_r;

  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(StackDepth);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("stack count past depth");

  property p_halt_sticky;
    @(posedge clk) disable iff (!rst_n) halt_r |=> halt_r;
  endproperty
  a_halt_sticky: assert property (p_halt_sticky) else $error("halt cleared");

  property p_halt_pc;
    @(posedge clk) disable iff (!rst_n) halt_r |=> $stable(pc_r) && $stable(cnt_r);
  endproperty
  a_halt_pc: assert property (p_halt_pc) else $error("state changed while halted");
endmodule
